// ===== src/mcq_pkg.sv =====
// Package for the motor command queue: command and frame-kind codes,
// register indexes, reset values and the queue slot type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mcq_pkg;

	localparam logic [2:0] CMD_ENABLE  = 3'd0;
	localparam logic [2:0] CMD_DISABLE = 3'd1;
	localparam logic [2:0] CMD_STOP    = 3'd2;
	localparam logic [2:0] CMD_SPEED   = 3'd3;
	localparam logic [2:0] CMD_TAKE    = 3'd4;

	localparam logic [1:0] KIND_SPEED   = 2'd0;
	localparam logic [1:0] KIND_ENABLE  = 2'd1;
	localparam logic [1:0] KIND_DISABLE = 2'd2;
	localparam logic [1:0] KIND_STOP    = 2'd3;

	localparam logic REG_MAX_SPEED = 1'b0;
	localparam logic REG_SETTLE    = 1'b1;

	localparam logic [15:0] MAX_SPEED_RST = 16'd3000;
	localparam logic [15:0] SETTLE_RST    = 16'd100;

	typedef struct packed {
		logic [7:0]  addr;
		logic [1:0]  kind;
		logic [7:0]  dir;
		logic [15:0] rpm;
		logic [7:0]  acc;
		logic [31:0] due;
	} entry_t;

endpackage
`default_nettype wire

// ===== src/mcq_if.sv =====
// Request and frame channel interfaces of the motor command queue.
// Valid/ready handshake with the payload alongside; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface mcq_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [7:0]  addr;
	logic [7:0]  direction;
	logic [15:0] speed;
	logic [7:0]  accel;
	logic [31:0] now;
	modport source (output valid, command, addr, direction, speed, accel, now, input ready);
	modport sink (input valid, command, addr, direction, speed, accel, now, output ready);
endinterface

interface mcq_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        frame_valid;
	logic [1:0]  frame_kind;
	logic [7:0]  frame_addr;
	logic [7:0]  frame_direction;
	logic [15:0] frame_speed;
	logic [7:0]  frame_accel;
	logic [31:0] dropped_total;
	logic [4:0]  pending;
	modport source (output valid, accepted, frame_valid, frame_kind, frame_addr,
		frame_direction, frame_speed, frame_accel, dropped_total, pending, input ready);
	modport sink (input valid, accepted, frame_valid, frame_kind, frame_addr,
		frame_direction, frame_speed, frame_accel, dropped_total, pending, output ready);
endinterface
`default_nettype wire

// ===== src/motor_command_priority_queue.sv =====
// Top level of the motor command queue: sequencer, queue slots, address tables.
// Depends on mcq_pkg, mcq_if (mcq_in_if, mcq_out_if) and mcq_ram.
//
// Use: requests enter on cmd (enable, disable, stop, speed, take-next) and every
// request gives exactly one response on rsp: accepted flag, the frame taken by a
// take-next, the drop count and the queue fill after the request. max_speed and
// enable_settle_ticks are written over the APB port at 0x0 and 0x4 while idle.
// One request is worked on at a time; cmd.ready is high only when idle.
// Steps per request; the queue slots are scanned one slot per cycle:
//   stop / disable / speed / take-next / enable: a scan of the filled slots (stop
//   and disable purge their speed commands first; speed scans only if enabled);
//   addressed enable or disable: refresh of group row 0 from rows 1..GROUP_SIZE;
//   broadcast enable or disable: a sweep that writes every table row in turn.
// At reset the queue is empty, the drop count is zero, all table rows read as
// disabled with ready tick zero, and the registers take 3000 and 100.
// The response sits in an output register; while rsp.ready is low it holds and
// the next request waits before its response is loaded.
`timescale 1ns / 1ps
`default_nettype none
module motor_command_priority_queue #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int ADDRESS_COUNT = 256,
	parameter int GROUP_SIZE    = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	mcq_in_if.sink           cmd,
	mcq_out_if.source        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import mcq_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(ADDRESS_COUNT);

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b000000000001,
		ST_PURGE   = 12'b000000000010,
		ST_TBL_RD  = 12'b000000000100,
		ST_SCAN    = 12'b000000001000,
		ST_DECIDE  = 12'b000000010000,
		ST_APPEND  = 12'b000000100000,
		ST_TABLE   = 12'b000001000000,
		ST_SWEEP   = 12'b000010000000,
		ST_GRP_RD  = 12'b000100000000,
		ST_GRP_ACC = 12'b001000000000,
		ST_GRP_WR  = 12'b010000000000,
		ST_OUT     = 12'b100000000000
	} state_t;

	state_t      state_q;
	logic [2:0]  cmd_q;
	logic [1:0]  kind_q;
	logic [7:0]  addr_q;
	logic [7:0]  dir_q;
	logic [15:0] rpm_q;
	logic [7:0]  acc_q;
	logic [31:0] now_q;
	logic [31:0] tick_q;
	logic [31:0] due_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] fill_q;
	logic [31:0] drop_q;
	logic [15:0] max_speed_q;
	logic [15:0] settle_q;
	logic        safe_f_q, spd_f_q, mrg_f_q;
	logic [IW-1:0] safe_i_q, spd_i_q, mrg_i_q;
	logic        res_acc_q, res_fv_q;
	logic [1:0]  res_kind_q;
	logic [7:0]  res_addr_q, res_dir_q, res_accel_q;
	logic [15:0] res_rpm_q;
	logic        valid_q [ADDRESS_COUNT];
	logic        rd_vld_q;
	logic [AW-1:0] sw_q;
	logic [7:0]  g_q;
	logic        all_q;
	logic [31:0] hi_q;
	logic        ov_q;
	logic        o_acc_q, o_fv_q;
	logic [1:0]  o_kind_q;
	logic [7:0]  o_addr_q, o_dir_q, o_accel_q;
	logic [15:0] o_rpm_q;
	logic [31:0] o_drop_q;
	logic [4:0]  o_pend_q;

	entry_t      q_q [QUEUE_DEPTH];
	entry_t      cur, sel, new_e;
	logic        q_rm, q_wr, q_app;
	logic [IW-1:0] q_rm_idx, q_wr_idx;
	logic        ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [32:0] ram_wdata, ram_rdata;
	logic        in_scan, in_range, full, due_ok, purge_hit, tbl_flag, grp_last;
	logic [31:0] due_diff, rd_tick;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		prdata = 32'd0;
		unique case (paddr[2])
			REG_MAX_SPEED: prdata = {16'd0, max_speed_q};
			REG_SETTLE:    prdata = {16'd0, settle_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign cmd.ready = (state_q == ST_IDLE);

	assign rsp.valid           = ov_q;
	assign rsp.accepted        = o_acc_q;
	assign rsp.frame_valid     = o_fv_q;
	assign rsp.frame_kind      = o_kind_q;
	assign rsp.frame_addr      = o_addr_q;
	assign rsp.frame_direction = o_dir_q;
	assign rsp.frame_speed     = o_rpm_q;
	assign rsp.frame_accel     = o_accel_q;
	assign rsp.dropped_total   = o_drop_q;
	assign rsp.pending         = o_pend_q;

	mcq_ram #(.WIDTH(33), .DEPTH(ADDRESS_COUNT)) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cur       = q_q[scan_q[IW-1:0]];
	assign sel       = safe_f_q ? q_q[safe_i_q] : q_q[spd_i_q];
	assign in_scan   = (scan_q < fill_q);
	assign full      = (fill_q == CW'(QUEUE_DEPTH));
	assign in_range  = ({1'b0, addr_q} < 9'(ADDRESS_COUNT));
	assign due_diff  = now_q - q_q[spd_i_q].due;
	assign due_ok    = !due_diff[31];
	assign purge_hit = (cur.kind == KIND_SPEED) &&
		((addr_q == 8'd0) || (cur.addr == addr_q) || (cur.addr == 8'd0));
	assign tbl_flag  = (cmd_q == CMD_ENABLE);
	assign rd_tick   = rd_vld_q ? ram_rdata[31:0] : 32'd0;
	assign grp_last  = (g_q == 8'(GROUP_SIZE)) || ({1'b0, g_q} == 9'(ADDRESS_COUNT - 1));
	assign new_e     = '{addr: addr_q, kind: kind_q, dir: dir_q, rpm: rpm_q,
		acc: acc_q, due: due_q};

	always_comb begin
		q_rm      = 1'b0;
		q_rm_idx  = '0;
		q_wr      = 1'b0;
		q_app     = 1'b0;
		q_wr_idx  = fill_q[IW-1:0];
		ram_we    = 1'b0;
		ram_waddr = addr_q[AW-1:0];
		ram_wdata = {tbl_flag, tbl_flag ? tick_q : 32'd0};
		ram_raddr = addr_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: ram_raddr = cmd.addr[AW-1:0];
			ST_PURGE: begin
				if (in_scan && purge_hit) begin
					q_rm     = 1'b1;
					q_rm_idx = scan_q[IW-1:0];
				end
			end
			ST_DECIDE: begin
				case (cmd_q)
					CMD_SPEED: begin
						if (mrg_f_q) begin
							q_wr     = 1'b1;
							q_wr_idx = mrg_i_q;
						end else if (!full) begin
							q_wr  = 1'b1;
							q_app = 1'b1;
						end
					end
					CMD_TAKE: begin
						if (safe_f_q) begin
							q_rm     = 1'b1;
							q_rm_idx = safe_i_q;
						end else if (spd_f_q && due_ok) begin
							q_rm     = 1'b1;
							q_rm_idx = spd_i_q;
						end
					end
					default: begin
						if (full && spd_f_q) begin
							q_rm     = 1'b1;
							q_rm_idx = spd_i_q;
						end
					end
				endcase
			end
			ST_APPEND: begin
				if (!full) begin
					q_wr  = 1'b1;
					q_app = 1'b1;
				end
			end
			ST_TABLE: ram_we = (addr_q != 8'd0) && in_range;
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sw_q;
			end
			ST_GRP_RD: ram_raddr = g_q[AW-1:0];
			ST_GRP_WR: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = {all_q, hi_q};
			end
			ST_TBL_RD, ST_SCAN, ST_GRP_ACC, ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_rm) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				if (IW'(i) >= q_rm_idx) begin
					q_q[i] <= q_q[i + 1];
				end
			end
		end
		if (q_wr) begin
			q_q[q_wr_idx] <= new_e;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) begin
			case (cmd.command)
				CMD_ENABLE:  kind_q <= KIND_ENABLE;
				CMD_DISABLE: kind_q <= KIND_DISABLE;
				CMD_STOP:    kind_q <= KIND_STOP;
				default:     kind_q <= KIND_SPEED;
			endcase
			cmd_q  <= cmd.command;
			addr_q <= cmd.addr;
			now_q  <= cmd.now;
			tick_q <= cmd.now + {16'd0, settle_q};
			dir_q  <= (cmd.command == CMD_SPEED) ? cmd.direction : 8'd0;
			acc_q  <= (cmd.command == CMD_SPEED) ? cmd.accel : 8'd0;
			rpm_q  <= (cmd.command != CMD_SPEED) ? 16'd0 :
				(cmd.speed > max_speed_q) ? max_speed_q : cmd.speed;
		end
		rd_vld_q <= valid_q[ram_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			drop_q      <= 32'd0;
			max_speed_q <= MAX_SPEED_RST;
			settle_q    <= SETTLE_RST;
			ov_q        <= 1'b0;
			for (int i = 0; i < ADDRESS_COUNT; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_MAX_SPEED: max_speed_q <= pwdata[15:0];
					REG_SETTLE:    settle_q    <= pwdata[15:0];
					default: ;
				endcase
			end
			if (q_rm) begin
				fill_q <= fill_q - CW'(1);
			end else if (q_app) begin
				fill_q <= fill_q + CW'(1);
			end
			if (rsp.ready && state_q != ST_OUT) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						scan_q      <= '0;
						safe_f_q    <= 1'b0;
						spd_f_q     <= 1'b0;
						mrg_f_q     <= 1'b0;
						res_acc_q   <= 1'b0;
						res_fv_q    <= 1'b0;
						res_kind_q  <= 2'd0;
						res_addr_q  <= 8'd0;
						res_dir_q   <= 8'd0;
						res_rpm_q   <= 16'd0;
						res_accel_q <= 8'd0;
						due_q       <= 32'd0;
						case (cmd.command)
							CMD_ENABLE, CMD_TAKE:  state_q <= ST_SCAN;
							CMD_DISABLE, CMD_STOP: state_q <= ST_PURGE;
							CMD_SPEED:             state_q <= ST_TBL_RD;
							default:               state_q <= ST_OUT;
						endcase
					end
				end
				ST_PURGE: begin
					if (!in_scan) begin
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end else if (!purge_hit) begin
						scan_q <= scan_q + CW'(1);
					end
				end
				ST_TBL_RD: begin
					if (in_range && rd_vld_q && ram_rdata[32]) begin
						due_q   <= rd_tick;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_SCAN: begin
					if (in_scan) begin
						if (cur.kind != KIND_SPEED && !safe_f_q) begin
							safe_f_q <= 1'b1;
							safe_i_q <= scan_q[IW-1:0];
						end
						if (cur.kind == KIND_SPEED && !spd_f_q) begin
							spd_f_q <= 1'b1;
							spd_i_q <= scan_q[IW-1:0];
						end
						if (cur.kind == KIND_SPEED && cur.addr == addr_q && !mrg_f_q) begin
							mrg_f_q <= 1'b1;
							mrg_i_q <= scan_q[IW-1:0];
						end
						scan_q <= scan_q + CW'(1);
					end else begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					case (cmd_q)
						CMD_SPEED: begin
							if (mrg_f_q || !full) begin
								res_acc_q <= 1'b1;
							end else begin
								drop_q <= drop_q + 32'd1;
							end
							state_q <= ST_OUT;
						end
						CMD_TAKE: begin
							if (safe_f_q || (spd_f_q && due_ok)) begin
								res_fv_q    <= 1'b1;
								res_kind_q  <= sel.kind;
								res_addr_q  <= sel.addr;
								res_dir_q   <= sel.dir;
								res_rpm_q   <= sel.rpm;
								res_accel_q <= sel.acc;
							end
							state_q <= ST_OUT;
						end
						default: state_q <= ST_APPEND;
					endcase
				end
				ST_APPEND: begin
					if (!full) begin
						res_acc_q <= 1'b1;
					end else begin
						drop_q <= drop_q + 32'd1;
					end
					if ((cmd_q == CMD_ENABLE && !full) || cmd_q == CMD_DISABLE) begin
						state_q <= ST_TABLE;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_TABLE: begin
					if (addr_q == 8'd0) begin
						sw_q    <= '0;
						state_q <= ST_SWEEP;
					end else begin
						if (in_range) begin
							valid_q[addr_q[AW-1:0]] <= 1'b1;
						end
						g_q     <= 8'd1;
						all_q   <= 1'b1;
						hi_q    <= 32'd0;
						state_q <= ST_GRP_RD;
					end
				end
				ST_SWEEP: begin
					valid_q[sw_q] <= 1'b1;
					if (sw_q == AW'(ADDRESS_COUNT - 1)) begin
						state_q <= ST_OUT;
					end else begin
						sw_q <= sw_q + AW'(1);
					end
				end
				ST_GRP_RD: state_q <= ST_GRP_ACC;
				ST_GRP_ACC: begin
					all_q <= all_q && rd_vld_q && ram_rdata[32];
					if (rd_tick > hi_q) begin
						hi_q <= rd_tick;
					end
					if (grp_last) begin
						state_q <= ST_GRP_WR;
					end else begin
						g_q     <= g_q + 8'd1;
						state_q <= ST_GRP_RD;
					end
				end
				ST_GRP_WR: begin
					valid_q[0] <= 1'b1;
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (!ov_q || rsp.ready) begin
						ov_q      <= 1'b1;
						o_acc_q   <= res_acc_q;
						o_fv_q    <= res_fv_q;
						o_kind_q  <= res_kind_q;
						o_addr_q  <= res_addr_q;
						o_dir_q   <= res_dir_q;
						o_rpm_q   <= res_rpm_q;
						o_accel_q <= res_accel_q;
						o_drop_q  <= drop_q;
						o_pend_q  <= 5'(fill_q);
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/mcq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mcq_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
